>>> design/fbjps_pkg.sv
// ----------------------------------------------------------------------------
// fbjps_pkg: shared types and constants for the forward/backward jet selector
// Beat formats, momentum widths and the cosh lookup table built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package fbjps_pkg;

  localparam int unsigned PT_W      = 16;
  localparam int unsigned ETA_W     = 12;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned COUNT_W   = 2;
  localparam int unsigned COSH_W    = 24;
  localparam int unsigned MOM_W     = 40;
  localparam int unsigned ETA_LIMIT = 1536;
  localparam int unsigned ADDR_W    = $clog2(ETA_LIMIT + 1);

  // Per-step growth and decay factors of e^(k/256) and e^(-k/256), Q28 start
  localparam logic [63:0] EXP_UP_STEP   = 64'd16810027;
  localparam logic [63:0] EXP_DOWN_STEP = 64'd16744491;
  localparam logic [63:0] EXP_ONE       = 64'd1 << 28;
  localparam logic [63:0] ROUND_HALF    = 64'd4096;
  localparam int unsigned ROUND_SHIFT   = 13;

  localparam int unsigned TABLE_W = (ETA_LIMIT + 1) * COSH_W;

  localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
  localparam logic [COUNT_W-1:0] COUNT_PAIR = 2'd2;

  typedef struct packed {
    logic [PT_W-1:0]         jet_pt;
    logic signed [ETA_W-1:0] jet_eta;
    logic                    has_jet;
    logic                    last;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   second_index;
    logic [COUNT_W-1:0] pair_count;
    logic               overflow;
  } out_beat_t;

  // One jet after the momentum multiply, as seen by the event tracker
  typedef struct packed {
    logic [MOM_W-1:0] mom;
    logic             eta_pos;
    logic             eta_neg;
    logic             has_jet;
    logic             last;
  } jet_item_t;

  // Step the two exponentials and pack cosh(k/256) in Q16, entry k at k*COSH_W
  function automatic logic [TABLE_W-1:0] build_cosh_table();
    logic [63:0]        up;
    logic [63:0]        down;
    logic [63:0]        sum;
    logic [TABLE_W-1:0] tab;
    up   = EXP_ONE;
    down = EXP_ONE;
    tab  = '0;
    for (int k = 0; k <= int'(ETA_LIMIT); k++) begin
      sum = up + down + ROUND_HALF;
      tab[k*COSH_W +: COSH_W] = sum[ROUND_SHIFT +: COSH_W];
      up   = up + ((up * EXP_UP_STEP) >> 32);
      down = down - ((down * EXP_DOWN_STEP) >> 32);
    end
    return tab;
  endfunction

  localparam logic [TABLE_W-1:0] COSH_TABLE = build_cosh_table();

endpackage

`default_nettype wire

>>> design/fbjps_cosh_rom.sv
// ----------------------------------------------------------------------------
// fbjps_cosh_rom: cosh lookup with registered read
// Returns cosh(|eta|/256) in Q16 from a register loaded while the read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module fbjps_cosh_rom (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [fbjps_pkg::ADDR_W-1:0]  addr_i,
  output logic      [fbjps_pkg::COSH_W-1:0]  data_o
);
  import fbjps_pkg::*;

  logic [COSH_W-1:0] data_q;
  logic [COSH_W-1:0] data_d;

  // Look up the entry; the address is clamped upstream
  assign data_d = COSH_TABLE[addr_i*COSH_W +: COSH_W];

  // Hold the read data while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> design/fbjps_tracker.sv
// ----------------------------------------------------------------------------
// fbjps_tracker: per-event best-jet bookkeeping
// Keeps the best forward, best backward and top two jets of the event and
// forms the selection for the closing beat from the updated state.
// ----------------------------------------------------------------------------
`default_nettype none

module fbjps_tracker #(
  parameter int unsigned MAX_JETS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire fbjps_pkg::jet_item_t  item_i,
  output fbjps_pkg::out_beat_t       result_o
);
  import fbjps_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_JETS + 1);
  localparam int unsigned EXT_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef struct packed {
    logic [MOM_W-1:0] mom;
    logic [IDX_W-1:0] idx;
  } cand_t;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  cand_t            fwd_q, fwd_d, bwd_q, bwd_d;
  cand_t            top1_q, top1_d, top2_q, top2_d;
  logic             fwd_found_q, fwd_found_d;
  logic             bwd_found_q, bwd_found_d;
  logic             ovf_q, ovf_d;

  logic [EXT_W-1:0] cnt_ext;
  cand_t            cur;
  logic             take;
  logic             fwd_upd, bwd_upd;
  logic             gt_top1, gt_top2;
  logic             fwd_first;
  logic [COUNT_W-1:0] count;

  // Index of the incoming jet, kept modulo 32
  assign cnt_ext  = EXT_W'(cnt_q);
  assign cur.mom  = item_i.mom;
  assign cur.idx  = cnt_ext[IDX_W-1:0];

  // Drop jets past capacity; a jet must beat the current best strictly
  assign take    = item_i.has_jet && (cnt_q < CNT_W'(MAX_JETS));
  assign fwd_upd = take && item_i.eta_pos && (item_i.mom > fwd_q.mom);
  assign bwd_upd = take && item_i.eta_neg && (item_i.mom > bwd_q.mom);
  assign gt_top1 = item_i.mom > top1_q.mom;
  assign gt_top2 = item_i.mom > top2_q.mom;

  // Next event state
  always_comb begin
    cnt_d       = cnt_q;
    fwd_d       = fwd_q;
    bwd_d       = bwd_q;
    top1_d      = top1_q;
    top2_d      = top2_q;
    fwd_found_d = fwd_found_q || fwd_upd;
    bwd_found_d = bwd_found_q || bwd_upd;
    ovf_d       = ovf_q || (item_i.has_jet && !take);
    if (fwd_upd) begin
      fwd_d = cur;
    end
    if (bwd_upd) begin
      bwd_d = cur;
    end
    if (take) begin
      cnt_d = cnt_q + CNT_W'(1);
      priority if (cnt_q == '0) begin
        top1_d = cur;
      end else if (gt_top1) begin
        top2_d = top1_q;
        top1_d = cur;
      end else if ((cnt_q == CNT_W'(1)) || gt_top2) begin
        top2_d = cur;
      end else begin
        // Hold both places for a jet that ranks below them
        top2_d = top2_q;
      end
    end
  end

  // Order the hemisphere pair from compares against the old state, in parallel
  always_comb begin
    priority if (fwd_upd) begin
      fwd_first = item_i.mom > bwd_q.mom;
    end else if (bwd_upd) begin
      fwd_first = fwd_q.mom > item_i.mom;
    end else begin
      fwd_first = fwd_q.mom > bwd_q.mom;
    end
  end

  // Form the selection from the updated state
  assign count = (cnt_d >= CNT_W'(2)) ? COUNT_PAIR : cnt_d[COUNT_W-1:0];

  always_comb begin
    result_o.overflow = ovf_d;
    if (fwd_found_d && bwd_found_d) begin
      result_o.pair_count   = COUNT_PAIR;
      result_o.first_index  = fwd_first ? fwd_d.idx : bwd_d.idx;
      result_o.second_index = fwd_first ? bwd_d.idx : fwd_d.idx;
    end else begin
      result_o.pair_count   = count;
      result_o.first_index  = (count != COUNT_NONE) ? top1_d.idx : '0;
      result_o.second_index = (count == COUNT_PAIR) ? top2_d.idx : '0;
    end
  end

  // Advance the state; clear it after the closing beat of an event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fwd_q       <= '0;
      bwd_q       <= '0;
      top1_q      <= '0;
      top2_q      <= '0;
      fwd_found_q <= 1'b0;
      bwd_found_q <= 1'b0;
      ovf_q       <= 1'b0;
    end else if (step_i) begin
      if (item_i.last) begin
        cnt_q       <= '0;
        fwd_q       <= '0;
        bwd_q       <= '0;
        top1_q      <= '0;
        top2_q      <= '0;
        fwd_found_q <= 1'b0;
        bwd_found_q <= 1'b0;
        ovf_q       <= 1'b0;
      end else begin
        cnt_q       <= cnt_d;
        fwd_q       <= fwd_d;
        bwd_q       <= bwd_d;
        top1_q      <= top1_d;
        top2_q      <= top2_d;
        fwd_found_q <= fwd_found_d;
        bwd_found_q <= bwd_found_d;
        ovf_q       <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/forward_backward_jet_pair_select.sv
// ----------------------------------------------------------------------------
// forward_backward_jet_pair_select: pick a jet pair per event
// One jet beat per cycle unless stalled; an event's result beat is registered
// after its closing beat is taken (cosh read, multiply, then tracker and output).
// Throughput is one beat per cycle unless stalled, as the tracker updates once per cycle.
// Reset clears the pipeline valids, the event state and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module forward_backward_jet_pair_select #(
  parameter int unsigned MAX_JETS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire fbjps_pkg::in_beat_t   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output fbjps_pkg::out_beat_t       out_data_o
);
  import fbjps_pkg::*;

  logic [ETA_W-1:0]  eta_u;
  logic [ETA_W-1:0]  eta_mag;
  logic [ADDR_W-1:0] rom_addr;
  logic [COSH_W-1:0] cosh_val;

  logic              in_acc;
  logic              s1_ready, s2_ready, s2_go, out_free;

  logic              s1_valid_q;
  logic [PT_W-1:0]   s1_pt_q;
  logic              s1_pos_q, s1_neg_q, s1_has_q, s1_last_q;

  logic              s2_valid_q;
  jet_item_t         s2_item_q, s2_item_d;

  out_beat_t         result;
  logic              out_valid_q;
  out_beat_t         out_data_q;

  // Clamp |eta| to the table range
  assign eta_u    = in_data_i.jet_eta;
  assign eta_mag  = eta_u[ETA_W-1] ? (~eta_u + ETA_W'(1)) : eta_u;
  assign rom_addr = (eta_mag > ETA_W'(ETA_LIMIT)) ? ADDR_W'(ETA_LIMIT)
                                                  : eta_mag[ADDR_W-1:0];

  // Pipeline flow: a beat that closes no event never waits on the output
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_go      = s2_valid_q && (!s2_item_q.last || out_free);
  assign s2_ready   = !s2_valid_q || s2_go;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;

  fbjps_cosh_rom u_cosh_rom (
    .clk_i  (clk_i),
    .en_i   (in_acc),
    .addr_i (rom_addr),
    .data_o (cosh_val)
  );

  // Stage 1: hold pt and eta sign beside the cosh read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pt_q   <= in_data_i.jet_pt;
      s1_pos_q  <= !eta_u[ETA_W-1] && (eta_u != '0);
      s1_neg_q  <= eta_u[ETA_W-1];
      s1_has_q  <= in_data_i.has_jet;
      s1_last_q <= in_data_i.last;
    end
  end

  // Multiply pt by cosh into the 40-bit momentum
  always_comb begin
    s2_item_d.mom     = MOM_W'(s1_pt_q) * MOM_W'(cosh_val);
    s2_item_d.eta_pos = s1_pos_q;
    s2_item_d.eta_neg = s1_neg_q;
    s2_item_d.has_jet = s1_has_q;
    s2_item_d.last    = s1_last_q;
  end

  // Stage 2: momentum register feeding the tracker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_item_q <= s2_item_d;
    end
  end

  fbjps_tracker #(
    .MAX_JETS (MAX_JETS)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s2_go),
    .item_i   (s2_item_q),
    .result_o (result)
  );

  // Output beat: load on a closing beat, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_go && s2_item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s2_item_q.last) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

>>> design/fbjps_checker.sv
// ----------------------------------------------------------------------------
// fbjps_checker: port-level checks on the jet pair selector
// Watches the result channel for held beats and consistent selections.
// ----------------------------------------------------------------------------
`default_nettype none

module fbjps_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire fbjps_pkg::in_beat_t  in_data_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire fbjps_pkg::out_beat_t out_data_o
);
  import fbjps_pkg::*;

  // Hold a stalled input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input beat changed while stalled");

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Never report more than a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pair_count == COUNT_NONE) ||
                    (out_data_o.pair_count == COUNT_ONE) ||
                    (out_data_o.pair_count == COUNT_PAIR))
    else $error("pair count out of range");

  // Zero the indices that the count does not cover
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.pair_count != COUNT_PAIR) |->
      (out_data_o.second_index == '0) &&
      ((out_data_o.pair_count != COUNT_NONE) || (out_data_o.first_index == '0)))
    else $error("uncovered index not zero");

  // An overflowing event holds at least two jets, so it reports a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.pair_count == COUNT_PAIR)
    else $error("overflow without a full pair");

endmodule

bind forward_backward_jet_pair_select fbjps_checker u_fbjps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
